[rtl/obb_obb_separating_axis_test_core_defines.svh]
// Assertion macros for the oriented box overlap test core
`ifndef OBB_OBB_SEPARATING_AXIS_TEST_CORE_DEFINES_SVH
`define OBB_OBB_SEPARATING_AXIS_TEST_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OBB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define OBB_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define OBB_ASSERT(lbl, clk, rstn, prop, msg)
`define OBB_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

[rtl/obb_pkg.sv]
// Shared types and constants for the oriented box overlap test core
`default_nettype none
package obb_pkg;
  localparam int AxisWidthDef  = 16;
  localparam int CoordWidthDef = 24;
  localparam int ExtWidth      = 20;
  localparam int BiasWidth     = 8;
  localparam logic [BiasWidth-1:0] BiasReset = 8'd1;

  // Controller phases
  typedef enum logic [2:0] {
    ST_IDLE, ST_ROT, ST_PROJ, ST_FACE, ST_EDGE, ST_DONE
  } obb_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       rot;
    logic       proj;
    logic       face;
    logic       edge_ax;
    logic [3:0] idx;
  } obb_cmd_t;

  // Datapath status
  typedef struct packed {
    logic sep;
  } obb_sts_t;
endpackage
`default_nettype wire

[rtl/obb_ctrl.sv]
// Controller state machine sequencing the axis tests
`default_nettype none
`include "obb_obb_separating_axis_test_core_defines.svh"
module obb_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire logic            last_i,
  input  wire obb_pkg::obb_sts_t sts_i,
  output obb_pkg::obb_cmd_t    cmd_o,
  output logic                 busy,
  output logic                 done_o,
  output logic                 overlap_o
);
  import obb_pkg::*;
  obb_state_e state_q, state_d;
  logic [3:0] idx_q, idx_d;
  logic sep_q, sep_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      sep_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sep_q   <= sep_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    sep_d   = sep_q | sts_i.sep;
    cmd_o   = '0;
    cmd_o.idx = idx_q;
    busy    = (state_q != ST_IDLE);
    done_o  = 1'b0;
    overlap_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        sep_d = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            state_d = ST_ROT;
            idx_d   = '0;
          end
        end
      end
      ST_ROT: begin
        cmd_o.rot = 1'b1;
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd8) begin
          state_d = ST_PROJ;
          idx_d   = '0;
        end
      end
      ST_PROJ: begin
        cmd_o.proj = 1'b1;
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd5) begin
          state_d = ST_FACE;
          idx_d   = '0;
        end
      end
      ST_FACE: begin
        cmd_o.face = 1'b1;
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd5) begin
          state_d = ST_EDGE;
          idx_d   = '0;
        end
      end
      ST_EDGE: begin
        cmd_o.edge_ax = 1'b1;
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd8) begin
          state_d = ST_DONE;
          idx_d   = '0;
        end
      end
      ST_DONE: begin
        done_o    = 1'b1;
        overlap_o = ~sep_q;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `OBB_ASSERT(a_done_only_in_done, clk_i, rst_ni, !done_o || state_q == ST_DONE, "done out of phase")
  `OBB_ASSERT_NEXT(a_done_to_idle, clk_i, rst_ni, done_o, !busy, "no return to idle")
  `OBB_ASSERT_NEXT(a_last_starts, clk_i, rst_ni, start && !busy && last_i, state_q == ST_ROT, "test not started")
endmodule
`default_nettype wire

[rtl/obb_dp.sv]
// Datapath: box store, rotation terms, projections and axis compares
`default_nettype none
module obb_dp #(
  parameter int AXIS_WIDTH  = obb_pkg::AxisWidthDef,
  parameter int COORD_WIDTH = obb_pkg::CoordWidthDef
) (
  input  wire logic                          clk_i,
  input  wire obb_pkg::obb_cmd_t             cmd_i,
  input  wire logic [obb_pkg::BiasWidth-1:0] bias_i,
  input  wire logic                          box_select_i,
  input  wire logic [1:0]                    row_i,
  input  wire logic signed [AXIS_WIDTH-1:0]  axis_x_i,
  input  wire logic signed [AXIS_WIDTH-1:0]  axis_y_i,
  input  wire logic signed [AXIS_WIDTH-1:0]  axis_z_i,
  input  wire logic [obb_pkg::ExtWidth-1:0]  half_extent_i,
  input  wire logic signed [COORD_WIDTH-1:0] center_coord_i,
  output obb_pkg::obb_sts_t                  sts_o
);
  import obb_pkg::*;
  localparam int F  = AXIS_WIDTH - 2;
  localparam int RW = AXIS_WIDTH + 3;            // rounded rotation term
  localparam int TW = COORD_WIDTH + 1;           // centre difference
  localparam int PW = TW + AXIS_WIDTH + 2;       // exact projection
  localparam int W  = PW + RW + ExtWidth + 4;    // compare width

  logic signed [AXIS_WIDTH-1:0] ax_q [6][3];
  logic [ExtWidth-1:0]          ex_q [6];
  logic signed [COORD_WIDTH-1:0] ce_q [6];
  logic signed [RW-1:0] r_q [3][3];
  logic [RW-1:0]        ar_q [3][3];
  logic signed [PW-1:0] ta_q [3], tb_q [3];
  logic signed [PW-F:0] ta8_q [3];
  logic [2:0]           ld_slot;

  // Row store
  assign ld_slot = (box_select_i ? 3'd3 : 3'd0) + {1'b0, row_i};
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && row_i != 2'd3) begin
      ax_q[ld_slot][0] <= axis_x_i;
      ax_q[ld_slot][1] <= axis_y_i;
      ax_q[ld_slot][2] <= axis_z_i;
      ex_q[ld_slot] <= half_extent_i;
      ce_q[ld_slot] <= center_coord_i;
    end
  end

  // Rotation term: one dot product per cycle
  logic [1:0] ri, rj;
  logic signed [2*AXIS_WIDTH+1:0] rdot, rrnd;
  logic signed [RW-1:0] rv;
  always_comb begin
    ri = (cmd_i.idx >= 4'd6) ? 2'd2 : (cmd_i.idx >= 4'd3) ? 2'd1 : 2'd0;
    rj = 2'(cmd_i.idx - 4'(ri) * 4'd3);
    rdot = (2*AXIS_WIDTH+2)'(ax_q[{1'b0, ri}][0] * ax_q[3'd3 + {1'b0, rj}][0])
         + (2*AXIS_WIDTH+2)'(ax_q[{1'b0, ri}][1] * ax_q[3'd3 + {1'b0, rj}][1])
         + (2*AXIS_WIDTH+2)'(ax_q[{1'b0, ri}][2] * ax_q[3'd3 + {1'b0, rj}][2]);
    rrnd = (rdot + ((2*AXIS_WIDTH+2)'(1) <<< (F-1))) >>> F;
    rv = RW'(rrnd);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.rot) begin
      r_q[ri][rj]  <= rv;
      ar_q[ri][rj] <= RW'(rv < 0 ? -rv : rv) + RW'(bias_i);
    end
  end

  // Centre projections onto both boxes' axes
  logic signed [TW-1:0] t0, t1, t2;
  logic [2:0] pa;
  logic signed [PW-1:0] pv, prnd;
  always_comb begin
    t0 = TW'(ce_q[3]) - TW'(ce_q[0]);
    t1 = TW'(ce_q[4]) - TW'(ce_q[1]);
    t2 = TW'(ce_q[5]) - TW'(ce_q[2]);
    pa = 3'(cmd_i.idx);
    if (pa > 3'd5) pa = 3'd0;
    pv = PW'(t0 * ax_q[pa][0]) + PW'(t1 * ax_q[pa][1]) + PW'(t2 * ax_q[pa][2]);
    prnd = (pv + (PW'(1) <<< (F-1))) >>> F;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.proj) begin
      if (pa < 3'd3) begin
        ta_q[pa[1:0]]  <= pv;
        ta8_q[pa[1:0]] <= (PW-F+1)'(prnd);
      end else tb_q[2'(pa - 3'd3)] <= pv;
    end
  end

  // Axis test: face axes then edge cross axes
  logic signed [W-1:0] proj, rad, apj;
  logic [1:0] k, i1, i2, j1, j2, fi, fj;
  always_comb begin
    proj = '0;
    rad  = '0;
    fi = (cmd_i.idx >= 4'd6) ? 2'd2 : (cmd_i.idx >= 4'd3) ? 2'd1 : 2'd0;
    fj = 2'(cmd_i.idx - 4'(fi) * 4'd3);
    k  = 2'(cmd_i.idx > 4'd2 ? cmd_i.idx - 4'd3 : cmd_i.idx);
    if (k == 2'd3) k = 2'd0;
    i1 = (fi == 2'd2) ? 2'd0 : fi + 2'd1;
    i2 = (fi == 2'd0) ? 2'd2 : fi - 2'd1;
    j1 = (fj == 2'd2) ? 2'd0 : fj + 2'd1;
    j2 = (fj == 2'd0) ? 2'd2 : fj - 2'd1;
    if (cmd_i.face) begin
      if (cmd_i.idx < 4'd3) begin
        proj = W'(ta_q[k]);
        rad = (W'(ex_q[{1'b0, k}]) <<< F) + W'(ex_q[3]*ar_q[k][0])
            + W'(ex_q[4]*ar_q[k][1]) + W'(ex_q[5]*ar_q[k][2]);
      end else begin
        proj = W'(tb_q[k]);
        rad = (W'(ex_q[3'd3 + {1'b0, k}]) <<< F) + W'(ex_q[0]*ar_q[0][k])
            + W'(ex_q[1]*ar_q[1][k]) + W'(ex_q[2]*ar_q[2][k]);
      end
    end else begin
      proj = W'(ta8_q[i2] * r_q[i1][fj]) - W'(ta8_q[i1] * r_q[i2][fj]);
      rad = W'(ex_q[{1'b0, i1}]*ar_q[i2][fj]) + W'(ex_q[{1'b0, i2}]*ar_q[i1][fj])
          + W'(ex_q[3'd3 + {1'b0, j1}]*ar_q[fi][j2])
          + W'(ex_q[3'd3 + {1'b0, j2}]*ar_q[fi][j1]);
    end
    apj = proj < 0 ? -proj : proj;
    sts_o.sep = (cmd_i.face || cmd_i.edge_ax) && (apj > rad);
  end
endmodule
`default_nettype wire

[rtl/obb_obb_separating_axis_test_core.sv]
// Top level of the oriented box overlap test core
// Load six rows with start (busy stays low between them); the row with
// last high starts the test: 9 rotation terms, 6 projections and 15
// axis compares, one per cycle on the shared datapath, then a done state
// that presents the result. done_o pulses for one cycle with overlap_o
// valid; the receiver cannot stall it. Rate is bounded by the
// one-term-per-cycle datapath sequence.
`default_nettype none
module obb_obb_separating_axis_test_core #(
  parameter int AXIS_WIDTH  = obb_pkg::AxisWidthDef,
  parameter int COORD_WIDTH = obb_pkg::CoordWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cfg_we_i,
  input  wire logic [obb_pkg::BiasWidth-1:0] cfg_wdata_i,
  input  wire logic                          box_select_i,
  input  wire logic [1:0]                    row_i,
  input  wire logic signed [AXIS_WIDTH-1:0]  axis_x_i,
  input  wire logic signed [AXIS_WIDTH-1:0]  axis_y_i,
  input  wire logic signed [AXIS_WIDTH-1:0]  axis_z_i,
  input  wire logic [obb_pkg::ExtWidth-1:0]  half_extent_i,
  input  wire logic signed [COORD_WIDTH-1:0] center_coord_i,
  input  wire logic                          last_i,
  output logic                               done_o,
  output logic                               overlap_o
);
  import obb_pkg::*;
  logic [BiasWidth-1:0] bias_q;
  obb_cmd_t cmd;
  obb_sts_t sts;

  // Bias register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bias_q <= BiasReset;
    else if (cfg_we_i) bias_q <= cfg_wdata_i;
  end

  obb_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .last_i, .sts_i(sts), .cmd_o(cmd), .busy,
    .done_o, .overlap_o
  );

  obb_dp #(.AXIS_WIDTH(AXIS_WIDTH), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk_i, .cmd_i(cmd), .bias_i(bias_q), .box_select_i, .row_i, .axis_x_i,
    .axis_y_i, .axis_z_i, .half_extent_i, .center_coord_i, .sts_o(sts)
  );
endmodule
`default_nettype wire

[tb/obb_obb_separating_axis_test_core_tb.sv]
// Self-checking testbench for the oriented box overlap test core
`timescale 1ns / 100ps
`default_nettype none
module obb_obb_separating_axis_test_core_tb;
  localparam int AxW   = obb_pkg::AxisWidthDef;
  localparam int CoW   = obb_pkg::CoordWidthDef;
  localparam int ExW   = obb_pkg::ExtWidth;
  localparam int BiW   = obb_pkg::BiasWidth;
  localparam int Frac  = AxW - 2;
  localparam int Drain = 40;
  localparam int One   = 16384;

  typedef struct {
    logic                  box;
    logic [1:0]            row;
    logic signed [AxW-1:0] ax, ay, az;
    logic [obb_pkg::ExtWidth-1:0] ext;
    logic signed [CoW-1:0] cen;
    logic                  last;
  } obb_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [obb_pkg::BiasWidth-1:0] cfg_wdata_i = '0;
  logic box_select_i = 1'b0;
  logic [1:0] row_i = '0;
  logic signed [AxW-1:0] axis_x_i = '0, axis_y_i = '0, axis_z_i = '0;
  logic [obb_pkg::ExtWidth-1:0] half_extent_i = '0;
  logic signed [CoW-1:0] center_coord_i = '0;
  logic last_i = 1'b0;
  logic done_o, overlap_o;

  obb_obb_separating_axis_test_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .box_select_i(box_select_i), .row_i(row_i),
    .axis_x_i(axis_x_i), .axis_y_i(axis_y_i), .axis_z_i(axis_z_i),
    .half_extent_i(half_extent_i), .center_coord_i(center_coord_i),
    .last_i(last_i), .done_o(done_o), .overlap_o(overlap_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predictor state
  longint axes_q[18];
  longint ext_q[6];
  longint cen_q[6];
  longint bias_q = obb_pkg::BiasReset;

  obb_req_t pending_reqs[$];
  bit       overlap_exp[$];
  obb_req_t shown;
  int       idle_pct = 38;
  bit       hold_off = 1'b0;
  int       mismatches = 0;
  int       cycles_idle = 0;

  function automatic longint round_q(longint v);
    return (v + (64'sd1 <<< (Frac - 1))) >>> Frac;
  endfunction

  function automatic longint labs(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Separating axis test over the 15 candidate axes
  function automatic bit boxes_overlap();
    longint r[3][3], ar[3][3], t[3], ta[3], tb[3], ta8[3];
    longint ra, rb, d;
    int i1, i2, j1, j2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        longint s;
        s = 0;
        for (int k = 0; k < 3; k++) s += axes_q[i*3+k] * axes_q[9+j*3+k];
        r[i][j]  = round_q(s);
        ar[i][j] = labs(r[i][j]) + bias_q;
      end
    end
    for (int k = 0; k < 3; k++) t[k] = cen_q[3+k] - cen_q[k];
    for (int i = 0; i < 3; i++) begin
      ta[i] = 0;
      tb[i] = 0;
      for (int k = 0; k < 3; k++) begin
        ta[i] += t[k] * axes_q[i*3+k];
        tb[i] += t[k] * axes_q[9+i*3+k];
      end
      ta8[i] = round_q(ta[i]);
    end
    // face axes of A, then of B
    for (int i = 0; i < 3; i++) begin
      rb = ext_q[3]*ar[i][0] + ext_q[4]*ar[i][1] + ext_q[5]*ar[i][2];
      if (labs(ta[i]) > (ext_q[i] <<< Frac) + rb) return 1'b0;
    end
    for (int j = 0; j < 3; j++) begin
      ra = ext_q[0]*ar[0][j] + ext_q[1]*ar[1][j] + ext_q[2]*ar[2][j];
      if (labs(tb[j]) > ra + (ext_q[3+j] <<< Frac)) return 1'b0;
    end
    // edge cross axes
    for (int i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3;
      i2 = (i + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        ra = ext_q[i1]*ar[i2][j] + ext_q[i2]*ar[i1][j];
        rb = ext_q[3+j1]*ar[i][j2] + ext_q[3+j2]*ar[i][j1];
        d  = ta8[i2]*r[i1][j] - ta8[i1]*r[i2][j];
        if (labs(d) > ra + rb) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void apply_request(obb_req_t q);
    int slot;
    if (q.row != 2'd3) begin
      slot = q.box * 3 + q.row;
      axes_q[slot*3]   = q.ax;
      axes_q[slot*3+1] = q.ay;
      axes_q[slot*3+2] = q.az;
      ext_q[slot] = q.ext;
      cen_q[slot] = q.cen;
    end
    if (q.last) overlap_exp.push_back(boxes_overlap());
  endfunction

  // Driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) apply_request(shown);
      if (start && busy) begin
        // hold the request
      end else if (!hold_off && pending_reqs.size() > 0 &&
                   $urandom_range(99) >= idle_pct) begin
        shown = pending_reqs.pop_front();
        start          <= 1'b1;
        box_select_i   <= shown.box;
        row_i          <= shown.row;
        axis_x_i       <= shown.ax;
        axis_y_i       <= shown.ay;
        axis_z_i       <= shown.az;
        half_extent_i  <= shown.ext;
        center_coord_i <= shown.cen;
        last_i         <= shown.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        cycles_idle <= 0;
        if (overlap_exp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result overlap=%0b", overlap_o);
        end else begin
          bit want;
          want = overlap_exp.pop_front();
          if (overlap_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("overlap mismatch: expected %0b got %0b", want, overlap_o);
          end
        end
      end else begin
        cycles_idle <= cycles_idle + 1;
      end
    end
  end

  function automatic void push_req(int box, int row, int ax, int ay, int az,
                                   int ext, int cen, int last);
    obb_req_t q;
    q.box = 1'(box); q.row = 2'(row);
    q.ax = AxW'(ax); q.ay = AxW'(ay); q.az = AxW'(az);
    q.ext = ExW'(ext); q.cen = CoW'(cen); q.last = 1'(last);
    pending_reqs.push_back(q);
  endfunction

  function automatic int rand_axis_comp();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? One : -One;
      1: return 0;
      default: return int'($urandom_range(2 * One)) - One;
    endcase
  endfunction

  // Full six-row load in random order with random content
  function automatic void push_box_pair(int scale);
    int order[6];
    int s, tmp, c, e;
    for (int n = 0; n < 6; n++) order[n] = n;
    for (int n = 5; n > 0; n--) begin
      s = $urandom_range(n);
      tmp = order[n]; order[n] = order[s]; order[s] = tmp;
    end
    for (int n = 0; n < 6; n++) begin
      e = (scale == 0) ? $urandom_range(20'hFFFFF) : $urandom_range(scale);
      c = (scale == 0) ? int'($urandom()) : int'($urandom_range(4 * scale)) - 2 * scale;
      c = (c <<< 8) >>> 8;
      push_req(order[n] / 3, order[n] % 3, rand_axis_comp(), rand_axis_comp(),
               rand_axis_comp(), e, c, n == 5);
    end
  endfunction

  task automatic settle();
    while (pending_reqs.size() > 0 || start || overlap_exp.size() > 0) @(posedge clk_i);
    cycles_idle = 0;
    while (cycles_idle < Drain) @(posedge clk_i);
  endtask

  task automatic write_bias(int v);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= BiW'(v);
    bias_q = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int pairs);
    for (int p = 0; p < pairs; p++) begin
      if ($urandom_range(9) == 0) begin
        // noise: ignored row, stray last, lone row update
        push_req($urandom_range(1), 3, rand_axis_comp(), rand_axis_comp(),
                 rand_axis_comp(), $urandom_range(20'hFFFFF), $urandom(),
                 $urandom_range(1));
        push_req($urandom_range(1), $urandom_range(2), rand_axis_comp(),
                 rand_axis_comp(), rand_axis_comp(), $urandom_range(4000),
                 int'($urandom_range(8000)) - 4000, $urandom_range(1));
      end
      case ($urandom_range(7))
        0: push_box_pair(0);
        1, 2: push_box_pair(255);
        default: push_box_pair(4000);
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: axis-aligned unit boxes touching, apart, then extremes
    for (int n = 0; n < 6; n++)
      push_req(n / 3, n % 3, (n % 3 == 0) ? One : 0, (n % 3 == 1) ? One : 0,
               (n % 3 == 2) ? One : 0, 256, (n == 3) ? 512 : 0, n == 5);
    push_req(1, 0, -One, 0, 0, 256, 513, 1);
    push_req(1, 2, 0, 0, -One, 20'hFFFFF, 24'sh7FFFFF, 1);
    push_req(0, 2, One, One, One, 0, -24'sh800000, 0);
    push_req(1, 3, -One, -One, -One, 20'hFFFFF, -1, 1);
    push_req(0, 1, -One, One, -One, 20'hFFFFF, 24'sh7FFFFF, 1);
    push_req(0, 0, 16'sh5555, -16'sh2AAA, 0, 20'hAAAAA, 24'sh555555, 0);
    push_req(1, 1, 11585, 11585, 0, 20'h55555, -24'sh2AAAAA, 1);
    push_req(0, 3, 0, 0, 0, 0, 0, 0);
    write_bias(0);
    run_random(40);
    write_bias(255);
    idle_pct = 77;
    run_random(40);
    // sender waits for every result before continuing
    while (pending_reqs.size() > 120) @(posedge clk_i);
    hold_off = 1'b1;
    while (overlap_exp.size() > 0 || start) @(posedge clk_i);
    hold_off = 1'b0;
    write_bias($urandom_range(2, 254));
    idle_pct = 0;
    run_random(40);
    write_bias(1);
    run_random(8);
    settle();
    if (mismatches == 0 && overlap_exp.size() == 0) begin
      $display("obb_obb_separating_axis_test_core_tb: done, clean");
    end else begin
      $display("obb_obb_separating_axis_test_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("obb_obb_separating_axis_test_core_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
+incdir+rtl
rtl/obb_pkg.sv
rtl/obb_ctrl.sv
rtl/obb_dp.sv
rtl/obb_obb_separating_axis_test_core.sv
tb/obb_obb_separating_axis_test_core_tb.sv
